// ----- sv/ia64_pkg.sv -----
// ----------------------------------------------------------------------------
// ia64_pkg
// Op codes, pipeline depth and the payload type carried through the cells.
// ----------------------------------------------------------------------------
package ia64_pkg;

    localparam int unsigned W      = 64;
    localparam int unsigned STAGES = 64;   // one quotient bit per divider cell

    typedef enum logic [4:0] {
        OP_NEG  = 5'd0,  OP_NOT  = 5'd1,  OP_ABS  = 5'd2,  OP_BNOT = 5'd3,
        OP_CLZ  = 5'd4,  OP_CTZ  = 5'd5,  OP_POP  = 5'd6,  OP_BITW = 5'd7,
        OP_ADD  = 5'd8,  OP_SUB  = 5'd9,  OP_MUL  = 5'd10, OP_DIV  = 5'd11,
        OP_REM  = 5'd12, OP_AND  = 5'd13, OP_OR   = 5'd14, OP_XOR  = 5'd15,
        OP_SHL  = 5'd16, OP_SHRA = 5'd17, OP_SHRL = 5'd18, OP_MOD  = 5'd19,
        OP_MIN  = 5'd20, OP_MAX  = 5'd21, OP_EQ   = 5'd22, OP_NE   = 5'd23,
        OP_LE   = 5'd24, OP_LT   = 5'd25, OP_GE   = 5'd26, OP_GT   = 5'd27
    } op_t;

    // One item travelling down the divider row.
    typedef struct packed {
        logic         valid;
        logic         is_div;   // result comes from the divider
        logic [4:0]   op;
        logic [W-1:0] fixed;    // non-divide result (MUL fills it at cell 1)
        logic         err;
        logic [W-1:0] rem;      // partial remainder
        logic [W-1:0] quo;      // dividend shifting out, quotient shifting in
        logic [W-1:0] dsr;      // divisor magnitude
        logic         an;
        logic         bn;
        logic [W-1:0] b;
    } cell_t;

endpackage

// ----- sv/int64_alu_fold.sv -----
// ----------------------------------------------------------------------------
// int64_alu_fold
// Pipelined 64-bit signed integer ALU with a cell-per-bit divider row.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op, operand_a and operand_b with start high; a request is taken at
//   every rising edge where start is high and busy is low. busy is tied low:
//   a new request may enter every cycle.
//   Each request yields exactly one result on result/error with done high
//   for one cycle, in request order.
//   Every op passes the same registers in order: one input
//   register, 64 divider cells (one quotient bit each), one sign-fix/output
//   register. Non-divide ops ride the same row so ordering holds.
//   Throughput: one request per cycle.
//   The product is built over two stages and joins the row at cell 1.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; done is a plain strobe.
// ----------------------------------------------------------------------------
module int64_alu_fold
    import ia64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [4:0]   op,
    input  logic [W-1:0] operand_a,
    input  logic [W-1:0] operand_b,
    output logic         done,
    output logic [W-1:0] result,
    output logic         error
);

    cell_t        row [1:STAGES];
    cell_t        head_next;
    cell_t        head_reg;
    logic         head_valid_reg;
    cell_t        head_q;
    logic [W-1:0] prod;
    cell_t        c1;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [5:0]   sh;
    logic [6:0]   clz;
    logic [6:0]   ctz;
    logic [6:0]   pop;
    logic         lt_ab;
    logic         lt_ba;
    logic [W-1:0] fx;
    logic         fe;
    logic         dv;
    logic [W-1:0] q_s;
    logic [W-1:0] r_s;
    logic [W-1:0] r_next;
    logic         done_reg;
    logic [W-1:0] result_reg;
    logic         error_reg;

    assign busy = 1'b0;
    assign a    = operand_a;
    assign b    = operand_b;
    assign sh   = b[5:0];
    assign lt_ab = $signed(a) < $signed(b);
    assign lt_ba = $signed(b) < $signed(a);

    always_comb
    begin
        clz = 7'd64;
        for (int i = 0; i < W; i++)
            if (a[i]) clz = 7'(W - 1 - i);
        ctz = 7'd64;
        for (int i = W - 1; i >= 0; i--)
            if (a[i]) ctz = 7'(i);
        pop = '0;
        for (int i = 0; i < W; i++)
            pop = pop + 7'(a[i]);
    end

    always_comb
    begin
        fx = '0;
        fe = 1'b0;
        dv = 1'b0;
        case (op)
            OP_NEG:  fx = -a;
            OP_NOT:  fx = ~a;
            OP_ABS:  fx = a[W-1] ? -a : a;
            OP_BNOT: fx = ~a;
            OP_CLZ:  fx = W'(clz);
            OP_CTZ:  fx = W'(ctz);
            OP_POP:  fx = W'(pop);
            OP_BITW: fx = W'(7'd64 - clz);
            OP_ADD:  fx = a + b;
            OP_SUB:  fx = a - b;
            OP_MUL:  fx = '0;
            OP_DIV, OP_REM, OP_MOD:
            begin
                if (b == '0) fe = 1'b1;
                else         dv = 1'b1;
            end
            OP_AND:  fx = a & b;
            OP_OR:   fx = a | b;
            OP_XOR:  fx = a ^ b;
            OP_SHL:  fx = a << sh;
            OP_SHRA: fx = W'($signed(a) >>> sh);
            OP_SHRL: fx = a >> sh;
            OP_MIN:  fx = lt_ba ? b : a;
            OP_MAX:  fx = lt_ab ? b : a;
            OP_EQ:   fx = {W{a == b}};
            OP_NE:   fx = {W{a != b}};
            OP_LE:   fx = {W{!lt_ba}};
            OP_LT:   fx = {W{lt_ab}};
            OP_GE:   fx = {W{!lt_ab}};
            OP_GT:   fx = {W{lt_ba}};
            default: fe = 1'b1;
        endcase
    end

    always_comb
    begin
        head_next        = '0;
        head_next.valid  = start && !busy;
        head_next.is_div = dv;
        head_next.op     = op;
        head_next.fixed  = fx;
        head_next.err    = fe;
        head_next.rem    = '0;
        head_next.quo    = a[W-1] ? -a : a;
        head_next.dsr    = b[W-1] ? -b : b;
        head_next.an     = a[W-1];
        head_next.bn     = b[W-1];
        head_next.b      = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    always_comb
    begin
        head_q       = head_reg;
        head_q.valid = head_valid_reg;
    end

    ia64_mul u_mul
    (
        .clk (clk),
        .a   (a),
        .b   (b),
        .p   (prod)
    );

    // merge the product into the item as it enters cell 1
    always_comb
    begin
        c1 = row[1];
        if (row[1].op == OP_MUL) c1.fixed = prod;
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_row
        if (g == 0)
        begin : g_in
            ia64_cell u_cell (.clk(clk), .rst_n(rst_n), .din(head_q), .dout(row[g+1]));
        end
        else if (g == 1)
        begin : g_mrg
            ia64_cell u_cell (.clk(clk), .rst_n(rst_n), .din(c1), .dout(row[g+1]));
        end
        else
        begin : g_pl
            ia64_cell u_cell (.clk(clk), .rst_n(rst_n), .din(row[g]), .dout(row[g+1]));
        end
    end

    always_comb
    begin
        q_s = (row[STAGES].an != row[STAGES].bn) ? -row[STAGES].quo : row[STAGES].quo;
        r_s = row[STAGES].an ? -row[STAGES].rem : row[STAGES].rem;
        if (!row[STAGES].is_div)
            r_next = row[STAGES].fixed;
        else if (row[STAGES].op == OP_DIV)
            r_next = q_s;
        else if (row[STAGES].op == OP_MOD && r_s != '0 && row[STAGES].an != row[STAGES].bn)
            r_next = r_s + row[STAGES].b;
        else
            r_next = r_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= row[STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= r_next;
        error_reg  <= row[STAGES].err;
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign error  = error_reg;

endmodule

// ----- sv/ia64_mul.sv -----
// ----------------------------------------------------------------------------
// ia64_mul
// Low 64 bits of a 64x64 product, split into 32x32 partial products over
// two registered stages.
// ----------------------------------------------------------------------------
module ia64_mul
    import ia64_pkg::*;
(
    input  logic         clk,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] p
);

    logic [W-1:0] ll_reg;
    logic [31:0]  lh_reg;
    logic [31:0]  hl_reg;
    logic [W-1:0] ll_next;

    assign ll_next = a[31:0] * b[31:0];

    always_ff @(posedge clk)
    begin
        ll_reg  <= ll_next;
        lh_reg  <= 32'(a[31:0] * b[63:32]);
        hl_reg  <= 32'(a[63:32] * b[31:0]);
        p       <= {32'(ll_reg[63:32] + lh_reg + hl_reg), ll_reg[31:0]};
    end

endmodule

// ----- sv/ia64_cell.sv -----
// ----------------------------------------------------------------------------
// ia64_cell
// One restoring-division step on divide items: shift one dividend bit into the
// remainder, subtract the divisor if it fits, hand the item to the next cell.
// ----------------------------------------------------------------------------
module ia64_cell
    import ia64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t din,
    output cell_t dout
);

    cell_t        data_next;
    cell_t        data_reg;
    logic         valid_reg;
    logic [W:0]   trial;
    logic [W:0]   diff;

    always_comb
    begin
        data_next = din;
        trial     = {din.rem, din.quo[W-1]};
        diff      = trial - {1'b0, din.dsr};
        if (din.is_div)
        begin
            if (!diff[W])
            begin
                data_next.rem = diff[W-1:0];
                data_next.quo = {din.quo[W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = trial[W-1:0];
                data_next.quo = {din.quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ----- sv/ia64_chk.sv -----
// ----------------------------------------------------------------------------
// ia64_chk
// Port-level checks on the ALU pipeline.
// ----------------------------------------------------------------------------
module ia64_chk
    import ia64_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic [4:0]   op,
    input logic [W-1:0] operand_b,
    input logic         done,
    input logic         error
);

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(STAGES+2) done) else $error("lost request");

    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(start && !busy, STAGES+2) |-> !done) else $error("spurious result");

    a_badop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op > OP_GT) |-> ##(STAGES+2) error)
        else $error("bad op not flagged");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operand_b == '0 &&
         (op == OP_DIV || op == OP_REM || op == OP_MOD)) |-> ##(STAGES+2) error)
        else $error("zero divisor not flagged");

endmodule

bind int64_alu_fold ia64_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .operand_b (operand_b),
    .done      (done),
    .error     (error)
);
